// ----- src/segscan_pkg.sv -----
`default_nettype none

package segscan_pkg;

  // Display geometry
  localparam int NUM_DIGITS  = 4;
  localparam int DIGIT_IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int DIGIT_W     = 4;
  localparam int ENABLE_W    = 4;
  localparam int SEG_W       = 7;

  // Value conversion
  localparam int VALUE_W     = 24;
  localparam int FRAC_BITS   = 8;
  localparam int FRAC_W      = 2;
  localparam int SCALE_W     = 10;
  localparam int PROD_W      = VALUE_W - 1 + SCALE_W;
  localparam int SCALED_W    = PROD_W - FRAC_BITS;

  // Divide by ten: floor(x * ceil(2^28 / 10) / 2^28) is exact for x below 2^26
  localparam int DIV10_SHIFT = 28;
  localparam logic [SCALED_W-1:0] DIV10_MULT = SCALED_W'(26843546);
  localparam int DIV_PROD_W  = 2 * SCALED_W;
  localparam int QUOT_W      = DIV_PROD_W - DIV10_SHIFT;

  // Register port
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam logic REG_FRACTION_DIGITS = 1'b0;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TICK = 1'b1
  } command_t;

  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_t;

  typedef struct packed {
    command_t                   command;
    logic signed [VALUE_W-1:0]  value_fixed;
  } item_t;

  typedef struct packed {
    logic [ENABLE_W-1:0] digit_enable_n;
    logic [SEG_W-1:0]    segments;
    logic                decimal_point;
  } drive_t;

  // Converted beat handed from the conversion pipe to the scanner
  typedef struct packed {
    logic     valid;
    command_t command;
    digits_t  digits;
  } conv_t;

  function automatic logic [SCALE_W-1:0] pow10(input logic [FRAC_W-1:0] k);
    logic [SCALE_W-1:0] s;
    case (k)
      2'd0:    s = SCALE_W'(1);
      2'd1:    s = SCALE_W'(10);
      2'd2:    s = SCALE_W'(100);
      default: s = SCALE_W'(1000);
    endcase
    return s;
  endfunction

  // Segment pattern, bit 0 = A .. bit 6 = G; codes above nine show a "1"
  function automatic logic [SEG_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7C;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h06;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- src/segscan_convert.sv -----
`default_nettype none

module segscan_convert
  import segscan_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [FRAC_W-1:0] fraction_digits,
  input  logic              item_valid,
  output logic              item_stall,
  input  item_t             item,
  output conv_t             conv,
  input  logic              conv_stall
);

  // Input register
  logic                       s0_valid;
  command_t                   s0_cmd;
  logic signed [VALUE_W-1:0]  s0_value;
  logic                       s0_ready;

  // Stage j holds the value after j divisions and the j low digits found so far
  logic [NUM_DIGITS:0]  stg_valid;
  logic [NUM_DIGITS:0]  stg_ready;
  command_t             stg_cmd    [NUM_DIGITS+1];
  logic [SCALED_W-1:0]  stg_x      [NUM_DIGITS+1];
  digits_t              stg_digits [NUM_DIGITS+1];

  logic [PROD_W-1:0]     scaled_prod;
  logic [SCALED_W-1:0]   scaled;
  logic [DIV_PROD_W-1:0] div_prod [NUM_DIGITS];
  logic [QUOT_W-1:0]     quot     [NUM_DIGITS];
  logic [DIGIT_W-1:0]    rem      [NUM_DIGITS];
  digits_t               dig_next [NUM_DIGITS];

  // Back-pressure: a stage takes a beat when empty or when its beat moves on
  always_comb begin
    stg_ready[NUM_DIGITS] = !stg_valid[NUM_DIGITS] || !conv_stall;
    for (int j = NUM_DIGITS - 1; j >= 0; j--) begin
      stg_ready[j] = !stg_valid[j] || stg_ready[j+1];
    end
  end

  assign s0_ready   = !s0_valid || stg_ready[0];
  assign item_stall = !s0_ready;

  // Scale by 10^k and drop the fraction bits; negatives clamp to zero
  assign scaled_prod = PROD_W'(s0_value[VALUE_W-2:0]) * PROD_W'(pow10(fraction_digits));
  assign scaled      = s0_value[VALUE_W-1] ? '0 : scaled_prod[PROD_W-1:FRAC_BITS];

  // One decimal digit per stage: quotient by reciprocal, remainder from low bits
  always_comb begin
    for (int j = 0; j < NUM_DIGITS; j++) begin
      div_prod[j]    = DIV_PROD_W'(stg_x[j]) * DIV_PROD_W'(DIV10_MULT);
      quot[j]        = div_prod[j][DIV_PROD_W-1:DIV10_SHIFT];
      rem[j]         = stg_x[j][DIGIT_W-1:0] - quot[j][DIGIT_W-1:0] * DIGIT_W'(10);
      dig_next[j]    = stg_digits[j];
      dig_next[j][j] = rem[j];
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      stg_valid <= '0;
    end else begin
      if (s0_ready) s0_valid <= item_valid;
      if (stg_ready[0]) stg_valid[0] <= s0_valid;
      for (int j = 0; j < NUM_DIGITS; j++) begin
        if (stg_ready[j+1]) stg_valid[j+1] <= stg_valid[j];
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (s0_ready) begin
      s0_cmd   <= item.command;
      s0_value <= item.value_fixed;
    end
    if (stg_ready[0]) begin
      stg_cmd[0]    <= s0_cmd;
      stg_x[0]      <= scaled;
      stg_digits[0] <= '0;
    end
    for (int j = 0; j < NUM_DIGITS; j++) begin
      if (stg_ready[j+1]) begin
        stg_cmd[j+1]    <= stg_cmd[j];
        stg_x[j+1]      <= SCALED_W'(quot[j]);
        stg_digits[j+1] <= dig_next[j];
      end
    end
  end

  assign conv.valid   = stg_valid[NUM_DIGITS];
  assign conv.command = stg_cmd[NUM_DIGITS];
  assign conv.digits  = stg_digits[NUM_DIGITS];

  // A beat held back at the pipe's end is not dropped
  a_conv_held: assert property (@(posedge clk) disable iff (rst)
    conv.valid && conv_stall |=> conv.valid)
    else $error("converted beat lost while stalled");

  // The input only stalls when the input register holds a beat
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> s0_valid)
    else $error("input stalled with empty input register");

  // The lowest and highest digits leaving the pipe on a load are decimal digits
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    conv.valid && conv.command == CMD_LOAD |->
      conv.digits[0] <= 4'd9 && conv.digits[NUM_DIGITS-1] <= 4'd9)
    else $error("converted digit out of range");

endmodule

`default_nettype wire

// ----- src/segscan_scan.sv -----
`default_nettype none

module segscan_scan
  import segscan_pkg::*;
#(
  parameter int BLANK_TICKS = 10,
  parameter int ON_TICKS    = 3,
  parameter int OFF_TICKS   = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [FRAC_W-1:0] fraction_digits,
  input  conv_t             conv,
  output logic              conv_stall,
  output logic              drive_valid,
  output drive_t            drive,
  input  logic              drive_stall
);

  localparam int SLOT_TICKS = ON_TICKS + OFF_TICKS;
  localparam int CNT_MAX    = (BLANK_TICKS > SLOT_TICKS) ? BLANK_TICKS : SLOT_TICKS;
  localparam int CNT_W      = $clog2(CNT_MAX);

  // Frame position: blank region or a digit slot, tick count within it
  logic                   in_blank;
  logic [CNT_W-1:0]       cnt;
  logic [DIGIT_IDX_W-1:0] digit_idx;

  logic                   update_pending;
  digits_t                staged;
  digits_t                shown;
  logic [SEG_W-1:0]       seg_latch;
  logic                   dp_latch;
  logic [ENABLE_W-1:0]    last_enables;

  logic                   take;
  logic                   is_tick;
  logic                   frame_start;
  logic                   first_lit;
  logic [ENABLE_W-1:0]    tick_enables;
  logic [SEG_W-1:0]       glyph_now;
  logic                   dp_now;

  assign conv_stall  = drive_valid && drive_stall;
  assign take        = conv.valid && !conv_stall;
  assign is_tick     = conv.command == CMD_TICK;
  assign frame_start = in_blank && cnt == '0;
  assign first_lit   = !in_blank && cnt == '0;
  assign glyph_now   = glyph(shown[digit_idx]);
  assign dp_now      = digit_idx == fraction_digits;

  // Digit enables for the current tick (four digits, one enable each)
  always_comb begin
    tick_enables = '1;
    if (!in_blank && cnt < CNT_W'(ON_TICKS)) begin
      tick_enables[digit_idx] = 1'b0;
    end
  end

  // Frame state, digit stores and latched drive
  always_ff @(posedge clk) begin
    if (rst) begin
      in_blank       <= 1'b1;
      cnt            <= '0;
      digit_idx      <= '0;
      update_pending <= 1'b0;
      seg_latch      <= '0;
      dp_latch       <= 1'b0;
      last_enables   <= '1;
      drive_valid    <= 1'b0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        staged[i] <= DIGIT_W'(i);
        shown[i]  <= DIGIT_W'(i);
      end
    end else begin
      if (!conv_stall) drive_valid <= conv.valid;
      if (take && !is_tick) begin
        staged         <= conv.digits;
        update_pending <= 1'b1;
      end
      if (take && is_tick) begin
        last_enables <= tick_enables;
        if (frame_start && update_pending) begin
          shown          <= staged;
          update_pending <= 1'b0;
        end
        if (first_lit) begin
          seg_latch <= glyph_now;
          dp_latch  <= dp_now;
        end
        // advance the frame
        if (in_blank) begin
          if (cnt == CNT_W'(BLANK_TICKS - 1)) begin
            in_blank  <= 1'b0;
            cnt       <= '0;
            digit_idx <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end else if (cnt == CNT_W'(SLOT_TICKS - 1)) begin
          cnt <= '0;
          if (digit_idx == DIGIT_IDX_W'(NUM_DIGITS - 1)) begin
            in_blank <= 1'b1;
          end else begin
            digit_idx <= digit_idx + 1'b1;
          end
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  // Output register: a load repeats the last tick's drive
  always_ff @(posedge clk) begin
    if (take) begin
      if (is_tick) begin
        drive.digit_enable_n <= tick_enables;
        drive.segments       <= first_lit ? glyph_now : seg_latch;
        drive.decimal_point  <= first_lit ? dp_now : dp_latch;
      end else begin
        drive.digit_enable_n <= last_enables;
        drive.segments       <= seg_latch;
        drive.decimal_point  <= dp_latch;
      end
    end
  end

  // At most one digit is ever enabled
  a_one_digit: assert property (@(posedge clk) disable iff (rst)
    drive_valid |-> $onehot0(~drive.digit_enable_n))
    else $error("more than one digit enabled");

  // The frame-start copy consumes the pending update
  a_copy_clears: assert property (@(posedge clk) disable iff (rst)
    take && is_tick && frame_start && update_pending |=> !update_pending)
    else $error("pending update not consumed at frame start");

  // Blank ticks keep every digit dark
  a_blank_dark: assert property (@(posedge clk) disable iff (rst)
    take && is_tick && in_blank |=> drive.digit_enable_n == '1)
    else $error("digit lit during blank ticks");

endmodule

`default_nettype wire

// ----- src/four_digit_seven_segment_scanner.sv -----
// Four-digit multiplexed seven-segment display scanner.
//
// Input channel (item_valid / item_stall / item): each beat is either a load
// (command = CMD_LOAD) carrying a signed value with 8 fraction bits, or a
// one-millisecond tick (command = CMD_TICK). A load scales the value by
// 10^fraction_digits, truncates it and stages its four low decimal digits;
// negatives show as zero. Each tick advances a frame of
// BLANK_TICKS + 4 * (ON_TICKS + OFF_TICKS) ticks (26 by default); staged
// digits become visible at the next frame start.
// Output channel (drive_valid / drive_stall / drive): exactly one beat per
// input beat, in order: digit enables, segments and decimal point for that
// tick; a load repeats the drive of the latest tick.
// From input accept to drive_valid a beat passes the input register, the
// scaling multiply, one divide-by-ten stage per digit, then the scan stage.
// One beat per cycle is sustained while drive_stall is low; each stage holds its beat while the
// output is stalled, so drive_stall backs up to item_stall stage by stage.
// fraction_digits sits at byte address 0 of the register port; the user must write
// it only while the block is idle, which the block itself does not enforce.
// Reset clears the pipe, shows digits 3210 and starts the frame blank.

`default_nettype none

module four_digit_seven_segment_scanner
  import segscan_pkg::*;
#(
  parameter int BLANK_TICKS = 10,
  parameter int ON_TICKS    = 3,
  parameter int OFF_TICKS   = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               item_valid,
  output logic               item_stall,
  input  item_t              item,
  output logic               drive_valid,
  input  logic               drive_stall,
  output drive_t             drive
);

  logic [FRAC_W-1:0] fraction_digits;
  logic              reg_sel;
  conv_t             conv;
  logic              conv_stall;

  assign pready  = 1'b1;
  assign reg_sel = paddr[PADDR_W-1];

  // Register write
  always_ff @(posedge clk) begin
    if (rst) begin
      fraction_digits <= '0;
    end else if (psel && penable && pwrite && pready &&
                 reg_sel == REG_FRACTION_DIGITS) begin
      fraction_digits <= pwdata[FRAC_W-1:0];
    end
  end

  // Register read
  always_comb begin
    unique case (reg_sel)
      REG_FRACTION_DIGITS: prdata = PDATA_W'(fraction_digits);
      default:             prdata = '0;
    endcase
  end

  segscan_convert u_convert (
    .clk             (clk),
    .rst             (rst),
    .fraction_digits (fraction_digits),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .item            (item),
    .conv            (conv),
    .conv_stall      (conv_stall)
  );

  segscan_scan #(
    .BLANK_TICKS (BLANK_TICKS),
    .ON_TICKS    (ON_TICKS),
    .OFF_TICKS   (OFF_TICKS)
  ) u_scan (
    .clk             (clk),
    .rst             (rst),
    .fraction_digits (fraction_digits),
    .conv            (conv),
    .conv_stall      (conv_stall),
    .drive_valid     (drive_valid),
    .drive           (drive),
    .drive_stall     (drive_stall)
  );

endmodule

`default_nettype wire

// ----- verif/tb_four_digit_seven_segment_scanner.sv -----
`default_nettype none

module tb_four_digit_seven_segment_scanner;
  import segscan_pkg::*;

  // Scan timing, kept equal to the block's defaults
  localparam int BLANK_TICKS = 10;
  localparam int ON_TICKS    = 3;
  localparam int OFF_TICKS   = 1;
  localparam int SLOT_TICKS  = ON_TICKS + OFF_TICKS;
  localparam int FRAME_TICKS = BLANK_TICKS + NUM_DIGITS * SLOT_TICKS;

  localparam int unsigned PIPE_LATENCY = 6;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned PHASE_ITEMS  = 290;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  localparam logic [PADDR_W-1:0] ADDR_FRACTION_DIGITS = PADDR_W'(4 * REG_FRACTION_DIGITS);
  localparam logic [PADDR_W-1:0] ADDR_SPARE           = PADDR_W'(4);

  localparam logic [SEG_W-1:0] DIGIT_GLYPH [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7C, 7'h07, 7'h7F, 7'h6F
  };
  localparam int unsigned DEC_SCALE [4] = '{1, 10, 100, 1000};

  // Tracks the display state and checks every drive beat in order
  class drive_scoreboard;
    drive_t             expected_drives [$];
    logic [FRAC_W-1:0]  point_pos;
    logic [DIGIT_W-1:0] staged_value [NUM_DIGITS];
    logic [DIGIT_W-1:0] shown_value [NUM_DIGITS];
    bit                 swap_pending;
    int unsigned        scan_phase;
    logic [SEG_W:0]     lit_pattern;
    int unsigned        errors;
    int unsigned        loads;
    int unsigned        ticks;
    int unsigned        points_lit;
    int unsigned        beats_checked;

    function new();
      point_pos = '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        staged_value[i] = DIGIT_W'(i);
        shown_value[i]  = DIGIT_W'(i);
      end
      swap_pending  = 1'b0;
      scan_phase    = 0;
      lit_pattern   = '0;
      errors        = 0;
      loads         = 0;
      ticks         = 0;
      points_lit    = 0;
      beats_checked = 0;
    endfunction

    function void set_point_pos(logic [FRAC_W-1:0] k);
      point_pos = k;
    endfunction

    function int unsigned pending();
      return expected_drives.size();
    endfunction

    // Advance the display state by one accepted beat and queue its drive
    function void note_item(item_t it);
      drive_t      want;
      int unsigned p;
      int unsigned dig;
      int unsigned rem;
      longint      scaled;
      if (it.command == CMD_LOAD) begin
        loads++;
        scaled = 0;
        // negatives clamp to zero
        if (!it.value_fixed[VALUE_W-1])
          scaled = (longint'(it.value_fixed) * DEC_SCALE[point_pos]) >> FRAC_BITS;
        for (int i = 0; i < NUM_DIGITS; i++) begin
          staged_value[i] = DIGIT_W'(scaled % 10);
          scaled = scaled / 10;
        end
        swap_pending = 1'b1;
        // a load repeats the latest tick's drive
        p = (scan_phase == 0) ? FRAME_TICKS - 1 : scan_phase - 1;
      end else begin
        ticks++;
        p = scan_phase;
        if (p == 0 && swap_pending) begin
          shown_value  = staged_value;
          swap_pending = 1'b0;
        end
        if (p >= BLANK_TICKS) begin
          dig = (p - BLANK_TICKS) / SLOT_TICKS;
          rem = (p - BLANK_TICKS) % SLOT_TICKS;
          if (rem == 0 && dig < NUM_DIGITS)
            lit_pattern = {dig == point_pos, DIGIT_GLYPH[shown_value[dig]]};
        end
        scan_phase = (p + 1 >= FRAME_TICKS) ? 0 : p + 1;
      end
      // enables for phase p, active low
      want.digit_enable_n = '1;
      if (p >= BLANK_TICKS) begin
        dig = (p - BLANK_TICKS) / SLOT_TICKS;
        rem = (p - BLANK_TICKS) % SLOT_TICKS;
        if (rem < ON_TICKS && dig < ENABLE_W)
          want.digit_enable_n = ~(ENABLE_W'(1) << dig);
      end
      want.segments      = lit_pattern[SEG_W-1:0];
      want.decimal_point = lit_pattern[SEG_W];
      if (want.decimal_point && want.digit_enable_n != '1)
        points_lit++;
      expected_drives.push_back(want);
    endfunction

    function void check_drive(drive_t got);
      drive_t want;
      if (expected_drives.size() == 0) begin
        $error("drive beat with nothing expected: %p", got);
        errors++;
        return;
      end
      want = expected_drives.pop_front();
      beats_checked++;
      if (got.digit_enable_n !== want.digit_enable_n) begin
        $error("digit_enable_n: expected %h, actual %h", want.digit_enable_n,
               got.digit_enable_n);
        errors++;
      end
      if (got.segments !== want.segments) begin
        $error("segments: expected %h, actual %h", want.segments, got.segments);
        errors++;
      end
      if (got.decimal_point !== want.decimal_point) begin
        $error("decimal_point: expected %b, actual %b", want.decimal_point,
               got.decimal_point);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               item_valid;
  logic               item_stall;
  item_t              item;
  logic               drive_valid;
  logic               drive_stall;
  drive_t             drive;

  drive_scoreboard sb;
  bit              src_idle;
  bit              sink_idle;
  bit              hold_long_req;
  int unsigned     long_holds;
  int unsigned     cycle_count = 0;

  four_digit_seven_segment_scanner #(
    .BLANK_TICKS (BLANK_TICKS),
    .ON_TICKS    (ON_TICKS),
    .OFF_TICKS   (OFF_TICKS)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .drive_valid (drive_valid),
    .drive_stall (drive_stall),
    .drive       (drive)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_four_digit_seven_segment_scanner: done, errors");
      $finish;
    end
  end

  // Output beats
  always @(posedge clk) begin
    if (!rst && drive_valid && !drive_stall)
      sb.check_drive(drive);
  end

  // Receiver: random stall bursts, plus one long hold on request
  initial begin : drive_sink
    int unsigned hold_left;
    bit          stall_next;
    drive_stall = 1'b0;
    hold_left   = 0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (hold_long_req) begin
        hold_long_req = 1'b0;
        hold_left     = LONG_HOLD - 1;
        stall_next    = 1'b1;
        long_holds++;
      end else if (sink_idle && $urandom_range(0, 9) == 0) begin
        hold_left  = $urandom_range(0, 12);
        stall_next = 1'b1;
      end else begin
        stall_next = 1'b0;
      end
      drive_stall <= stall_next;
    end
  end

  // Setup and access phases, then the bus goes idle
  task automatic reg_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_read_check(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      $error("fraction_digits readback: expected %h, actual %h", want, prdata);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_fraction_digits(logic [FRAC_W-1:0] k);
    // upper data bits are junk; only the low field is kept
    reg_write(ADDR_FRACTION_DIGITS, {30'($urandom), k});
    sb.set_point_pos(k);
    reg_read_check(ADDR_FRACTION_DIGITS, PDATA_W'(k));
  endtask

  // One input beat; an optional gap follows acceptance
  task automatic send_item(item_t it);
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_item(it);
    if (src_idle && $urandom_range(0, 5) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic send_load(logic [VALUE_W-1:0] v);
    item_t it;
    it.command     = CMD_LOAD;
    it.value_fixed = v;
    send_item(it);
  endtask

  task automatic send_tick();
    item_t it;
    it.command     = CMD_TICK;
    it.value_fixed = VALUE_W'($urandom);
    send_item(it);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value(logic [FRAC_W-1:0] k);
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = VALUE_W'($urandom);
      3, 4:    v = VALUE_W'($urandom) | 24'h800000;
      5: begin
        case ($urandom_range(0, 5))
          0:       v = '0;
          1:       v = 24'h7FFFFF;
          2:       v = 24'h800000;
          3:       v = '1;
          4:       v = 24'h000100;
          default: v = 24'h0000FF;
        endcase
      end
      // mostly values that fit in four shown digits
      default: v = VALUE_W'($urandom_range(0, 2560000 / DEC_SCALE[k]));
    endcase
    return v;
  endfunction

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_random(int unsigned count, bit quiet, bit with_hold);
    for (int unsigned n = 0; n < count; n++) begin
      // alternate stretches with and without idling
      if (n % 40 == 0) begin
        src_idle  = !quiet && ($urandom_range(0, 3) != 0);
        sink_idle = !quiet && ($urandom_range(0, 3) != 0);
      end
      if (with_hold && n == 60)
        hold_long_req = 1'b1;
      if ($urandom_range(0, 99) < 15)
        send_load(pick_value(sb.point_pos));
      else
        send_tick();
    end
    item_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [FRAC_W-1:0] frac_plan [6];
    frac_plan  = '{2'd3, 2'd0, 2'd2, 2'd1, 2'd3, 2'd0};
    sb         = new();
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    item_valid = 1'b0;
    item       = '0;
    src_idle   = 1'b1;
    sink_idle  = 1'b1;
    long_holds = 0;
    hold_long_req = 1'b0;
    rst        = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, negatives, all-nines, then part of a frame
    reg_read_check(ADDR_FRACTION_DIGITS, '0);
    send_load(24'h7FFFFF);
    send_load(24'h800000);
    send_load(24'hFFFFFF);
    send_load(24'h000001);
    send_load(24'h270F00);  // 9999.0
    repeat (20) send_tick();
    item_valid <= 1'b0;

    // Random phases, one point position each
    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      set_fraction_digits(frac_plan[ph]);
      if (ph == 4) begin
        // write to an unmapped address must leave the setting alone
        reg_write(ADDR_SPARE, $urandom);
        reg_read_check(ADDR_FRACTION_DIGITS, PDATA_W'(frac_plan[ph]));
      end
      run_random(PHASE_ITEMS, ph == 5, ph == 2);
    end

    wait_drained();
    repeat (PIPE_LATENCY + 10) @(posedge clk);
    $display("covered %0d loads and %0d ticks at point positions 0..3; %0d beats checked",
             sb.loads, sb.ticks, sb.beats_checked);
    $display("%0d beats with a lit decimal point, %0d long output hold(s)",
             sb.points_lit, long_holds);
    if (sb.errors == 0) begin
      $display("tb_four_digit_seven_segment_scanner: done, clean");
    end else begin
      $display("tb_four_digit_seven_segment_scanner: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
